FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/dlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants and register codes of the downmix linear resampler.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Default datapath sizes
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed register field widths
    localparam int CH_W       = 2;
    localparam int STEP_W     = 21;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 2;

    // Integer bits of the stored phase
    localparam int PHASE_INT_BITS = 6;

    // Result limit per input frame and its counter width
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    // Register reset values
    localparam logic [CH_W-1:0]   CHANNELS_RST = CH_W'(1);
    localparam logic              STEREO_RST   = 1'b0;
    localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(4096);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_CHANNELS = 2'd0,
        CFG_KEEP_STEREO    = 2'd1,
        CFG_STEP_RATIO     = 2'd2,
        CFG_GAIN_LINEAR    = 2'd3
    } t_cfg_index;

endpackage

FILE: sv/downmix_linear_resampler.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// Linear interpolation resampler with stereo downmix, gain, round and clip.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_sample_left, i_sample_right,
//                                                i_clip_end
// output    out        o_valid / i_ready         o_out_left, o_out_right,
//                                                o_run_last
// config    in         i_cfg_wr_en (no wait)     i_cfg_index, i_cfg_data
//
// A first frame of a clip that does not also end it is only stored. Any
// other frame is evaluated; then each output goes through setup and the
// single shared multiplier and its sequencer (once per channel in stereo),
// is rounded, and waits on i_ready. At most 64 outputs per frame.
// o_ready is high only in idle; one frame is worked on at a time.
// Reset is synchronous, active low; it clears the control registers and the clip state.
// ----------------------------------------------------------------------------
module downmix_linear_resampler
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // input frames
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    input  logic                          i_clip_end,
    // output samples
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic                          o_run_last
);

    // Widths
    localparam int PHASE_W = FRAC_BITS + PHASE_INT_BITS;
    localparam int PH_BASE = (PHASE_W > STEP_W) ? PHASE_W : STEP_W;
    localparam int PHW     = PH_BASE + 2;
    localparam int VAL_W   = SAMPLE_BITS + 1;
    localparam int DIF_W   = SAMPLE_BITS + 2;
    localparam int MIX_W   = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int HI_W    = MIX_W - GAIN_W;
    localparam int MA_T    = (DIF_W > HI_W) ? DIF_W : HI_W;
    localparam int MA_W    = (MA_T > GAIN_W + 1) ? MA_T : GAIN_W + 1;
    localparam int MB_W    = (FRAC_BITS > GAIN_W) ? FRAC_BITS + 1 : GAIN_W + 1;
    localparam int MP_W    = MA_W + MB_W;
    localparam int PROD_W  = MIX_W + GAIN_W + 1;
    localparam int SH      = FRAC_BITS + GAIN_FRAC + 1;
    localparam int Q_W     = PROD_W - SH;

    // Constants
    localparam logic [PHW-1:0]    ONE_POS = PHW'(1) << FRAC_BITS;
    localparam logic [PHW-1:0]    TWO_POS = PHW'(1) << (FRAC_BITS + 1);
    localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (SH - 1);
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [Q_W-1:0]         Q_MAX = Q_W'(S_MAX);
    localparam logic signed [Q_W-1:0]         Q_MIN = Q_W'(S_MIN);

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_EVAL  = 10'b00_0000_0010,
        S_SETUP = 10'b00_0000_0100,
        S_MUL_D = 10'b00_0000_1000,
        S_MIX   = 10'b00_0001_0000,
        S_MUL_H = 10'b00_0010_0000,
        S_MUL_L = 10'b00_0100_0000,
        S_ROUND = 10'b00_1000_0000,
        S_NEXT  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    // Channel value scaled by two: doubled sample or sum of both channels
    function automatic logic signed [VAL_W-1:0] chan_val(
        input logic signed [SAMPLE_BITS-1:0] xl,
        input logic signed [SAMPLE_BITS-1:0] xr,
        input logic                          second,
        input logic                          sum_both
    );
        logic signed [VAL_W-1:0] v;
        if (second) begin
            v = VAL_W'(xr) <<< 1;
        end else if (sum_both) begin
            v = VAL_W'(xl) + VAL_W'(xr);
        end else begin
            v = VAL_W'(xl) <<< 1;
        end
        return v;
    endfunction

    // Control registers
    t_state                  r_state, n_state;
    logic [CH_W-1:0]         r_input_channels, n_input_channels;
    logic                    r_keep_stereo, n_keep_stereo;
    logic [STEP_W-1:0]       r_step_ratio, n_step_ratio;
    logic [GAIN_W-1:0]       r_gain, n_gain;
    logic                    r_have_prev, n_have_prev;
    logic [PHASE_W-1:0]      r_phase, n_phase;
    logic signed [SAMPLE_BITS-1:0] r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic [CNT_W-1:0]        r_n, n_n;
    logic                    r_ch, n_ch;
    logic                    r_more, n_more;
    logic                    r_end, n_end;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] r_cur_l, n_cur_l, r_cur_r, n_cur_r;
    logic [PHW-1:0]          r_ph, n_ph;
    logic signed [VAL_W-1:0] r_a, n_a;
    logic signed [DIF_W-1:0] r_d, n_d;
    logic [FRAC_BITS-1:0]    r_frac, n_frac;
    logic signed [MP_W-1:0]  r_prod, n_prod, r_hprod, n_hprod;
    logic [MIX_W-1:0]        r_mix, n_mix;
    logic signed [SAMPLE_BITS-1:0] r_out_l, n_out_l, r_out_r, n_out_r;

    // Combinational helpers
    logic                    two_ch, stereo, sum_both;
    logic [PHW-1:0]          step_x, ph_plus, lim, ph_wrap;
    logic                    more, interp, do_finish;
    logic signed [VAL_W-1:0] pa, pb;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic [MIX_W-1:0]        mix_sum;
    logic signed [HI_W-1:0]  mix_hi;
    logic signed [PROD_W-1:0] hprod_x, lprod_x, t_sum;
    logic signed [Q_W-1:0]   q_val;
    logic signed [SAMPLE_BITS-1:0] sat;

    // Mode decode
    assign two_ch   = r_input_channels[CH_W-1];
    assign stereo   = r_keep_stereo && two_ch;
    assign sum_both = two_ch && !stereo;

    // Loop condition: room for another result and position still in range
    assign step_x  = PHW'(r_step_ratio);
    assign ph_plus = r_ph + step_x;
    assign lim     = r_have_prev ? TWO_POS : ONE_POS;
    assign more    = (r_n < CNT_W'(MAX_RESULTS))
                     && (r_end ? (ph_plus <= lim) : (r_ph < ONE_POS));
    assign ph_wrap = (r_ph >= ONE_POS) ? (r_ph - ONE_POS) : '0;

    // Interpolation end points of the current channel
    assign interp = r_have_prev && (r_ph < ONE_POS);
    assign pb     = chan_val(r_cur_l, r_cur_r, r_ch, sum_both);
    assign pa     = interp ? chan_val(r_prev_l, r_prev_r, r_ch, sum_both) : pb;

    // Shared multiplier and its operand selection
    assign mix_hi = r_mix[MIX_W-1:GAIN_W];
    always_comb begin
        case (r_state)
            S_MUL_H: begin
                mul_a = MA_W'(mix_hi);
                mul_b = MB_W'(r_gain);
            end
            S_MUL_L: begin
                mul_a = MA_W'(r_mix[GAIN_W-1:0]);
                mul_b = MB_W'(r_gain);
            end
            default: begin
                mul_a = MA_W'(r_d);
                mul_b = MB_W'(r_frac);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // a * one + (b - a) * frac
    assign mix_sum = (MIX_W'(r_a) <<< FRAC_BITS) + r_prod[MIX_W-1:0];

    // Recombine partial products, round half up, saturate
    assign hprod_x = PROD_W'(r_hprod);
    assign lprod_x = PROD_W'(r_prod);
    assign t_sum   = (hprod_x <<< GAIN_W) + lprod_x + HALF;
    assign q_val   = t_sum[PROD_W-1:SH];
    assign sat     = (q_val > Q_MAX) ? S_MAX
                   : (q_val < Q_MIN) ? S_MIN : q_val[SAMPLE_BITS-1:0];

    // Next-state logic
    always_comb begin
        n_state          = r_state;
        n_input_channels = r_input_channels;
        n_keep_stereo    = r_keep_stereo;
        n_step_ratio     = r_step_ratio;
        n_gain           = r_gain;
        n_have_prev      = r_have_prev;
        n_phase          = r_phase;
        n_prev_l         = r_prev_l;
        n_prev_r         = r_prev_r;
        n_n              = r_n;
        n_ch             = r_ch;
        n_more           = r_more;
        n_end            = r_end;
        n_cur_l          = r_cur_l;
        n_cur_r          = r_cur_r;
        n_ph             = r_ph;
        n_a              = r_a;
        n_d              = r_d;
        n_frac           = r_frac;
        n_prod           = r_prod;
        n_hprod          = r_hprod;
        n_mix            = r_mix;
        n_out_l          = r_out_l;
        n_out_r          = r_out_r;
        do_finish        = 1'b0;

        // register writes
        if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_INPUT_CHANNELS: n_input_channels = i_cfg_data[CH_W-1:0];
                CFG_KEEP_STEREO:    n_keep_stereo    = i_cfg_data[0];
                CFG_STEP_RATIO:     n_step_ratio     = i_cfg_data[STEP_W-1:0];
                CFG_GAIN_LINEAR:    n_gain           = i_cfg_data[GAIN_W-1:0];
                default:            n_gain           = r_gain;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cur_l = i_sample_left;
                    n_cur_r = i_sample_right;
                    n_end   = i_clip_end;
                    n_ph    = PHW'(r_phase);
                    n_n     = '0;
                    if (!r_have_prev && !i_clip_end) begin
                        // first frame of a clip: store only
                        n_prev_l    = i_sample_left;
                        n_prev_r    = i_sample_right;
                        n_have_prev = 1'b1;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (r_n == '0) begin
                    if (more) begin
                        n_ch    = 1'b0;
                        n_state = S_SETUP;
                    end else begin
                        do_finish = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_more  = more;
                    n_state = S_OUT;
                end
            end
            S_SETUP: begin
                n_a     = pa;
                n_d     = DIF_W'(pb) - DIF_W'(pa);
                n_frac  = interp ? r_ph[FRAC_BITS-1:0] : '0;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                n_prod  = mul_p;
                n_state = S_MIX;
            end
            S_MIX: begin
                n_mix   = mix_sum;
                n_state = S_MUL_H;
            end
            S_MUL_H: begin
                n_prod  = mul_p;
                n_state = S_MUL_L;
            end
            S_MUL_L: begin
                n_hprod = r_prod;
                n_prod  = mul_p;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_ch) begin
                    n_out_r = sat;
                end else begin
                    n_out_l = sat;
                    n_out_r = '0;
                end
                if (stereo && !r_ch) begin
                    n_ch    = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_ph    = ph_plus;
                n_n     = r_n + CNT_W'(1);
                n_state = S_EVAL;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_more) begin
                        n_ch    = 1'b0;
                        n_state = S_SETUP;
                    end else begin
                        do_finish = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // end of frame: wrap the phase, or clear the clip at its last frame
        if (do_finish) begin
            if (r_end) begin
                n_have_prev = 1'b0;
                n_phase     = '0;
                n_prev_l    = '0;
                n_prev_r    = '0;
            end else begin
                n_phase  = ph_wrap[PHASE_W-1:0];
                n_prev_l = r_cur_l;
                n_prev_r = r_cur_r;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_input_channels <= CHANNELS_RST;
            r_keep_stereo    <= STEREO_RST;
            r_step_ratio     <= STEP_RST;
            r_gain           <= GAIN_RST;
            r_have_prev      <= 1'b0;
            r_phase          <= '0;
            r_prev_l         <= '0;
            r_prev_r         <= '0;
            r_n              <= '0;
            r_ch             <= 1'b0;
            r_more           <= 1'b0;
            r_end            <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_input_channels <= n_input_channels;
            r_keep_stereo    <= n_keep_stereo;
            r_step_ratio     <= n_step_ratio;
            r_gain           <= n_gain;
            r_have_prev      <= n_have_prev;
            r_phase          <= n_phase;
            r_prev_l         <= n_prev_l;
            r_prev_r         <= n_prev_r;
            r_n              <= n_n;
            r_ch             <= n_ch;
            r_more           <= n_more;
            r_end            <= n_end;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cur_l <= n_cur_l;
        r_cur_r <= n_cur_r;
        r_ph    <= n_ph;
        r_a     <= n_a;
        r_d     <= n_d;
        r_frac  <= n_frac;
        r_prod  <= n_prod;
        r_hprod <= n_hprod;
        r_mix   <= n_mix;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

    // Ports
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_run_last  = !r_more;

    // Checks
    `ASSERT_ALWAYS(a_ready_valid_excl, i_clk, i_rst_n, !(o_ready && o_valid))
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_n <= CNT_W'(MAX_RESULTS))
    `ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, o_valid && i_ready && o_run_last, o_ready)
    `ASSERT_NEXT(a_store_first, i_clk, i_rst_n, i_valid && o_ready && !r_have_prev && !i_clip_end, r_have_prev && o_ready)

endmodule
